// File: rtl/gtgvc_pkg.sv
// gtgvc_pkg: widths, fixed-point constants, register indexes and arctan table
// for the go-to-goal velocity controller. No dependencies.
`default_nettype none
package gtgvc_pkg;

   localparam int POS_W      = 16;
   localparam int HEAD_W     = 15;
   localparam int ANG_W      = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int GUARD_BITS = 8;
   localparam int CW         = 28;   // cordic x/y, Q.20 plus growth
   localparam int ZW         = 32;   // angle accumulator, Q.28
   localparam int PART_W     = 15;   // split of the gain-correction constant
   localparam int MAX_STAGES = 24;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int PW         = CW - 1 + PART_W;          // partial product
   localparam int SUM_W      = PW + PART_W;              // recombined product
   localparam int DIST_SHIFT = 30 + GUARD_BITS;
   localparam int DIST_W     = SUM_W - DIST_SHIFT;
   localparam int LIN_PW     = POS_W + DIST_W;
   localparam int FRAC_W     = 12;
   localparam int BEAR_SHIFT = 16;
   localparam int BEAR_W     = ZW - BEAR_SHIFT;
   localparam int ERR_W      = BEAR_W + 1;

   localparam int INV_K_Q30  = 652032874;
   localparam logic [PART_W-1:0] K_HI = PART_W'(INV_K_Q30 >> PART_W);
   localparam logic [PART_W-1:0] K_LO = PART_W'(INV_K_Q30 % (1 << PART_W));

   localparam logic signed [ZW-1:0] HALF_PI_Q28 = 32'sd421657429;
   localparam logic signed [ZW-1:0] BEAR_ROUND  = ZW'(1 << (BEAR_SHIFT - 1));

   localparam logic [DIST_W-1:0] STOP_DIST = DIST_W'(41);
   localparam logic [ERR_W-1:0]  TURN_ERR  = ERR_W'(410);

   localparam logic [POS_W-1:0] TARGET_X_RST  = 16'd4096;
   localparam logic [POS_W-1:0] TARGET_Y_RST  = 16'd4096;
   localparam logic [POS_W-1:0] GAIN_RST      = 16'd4096;
   localparam logic [POS_W-1:0] MAX_SPEED_RST = 16'd12288;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED = 2'd3;

   localparam logic signed [ZW-1:0] ATAN_Q28 [MAX_STAGES] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
      32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
      32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
      32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
      32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
      32'sd256,       32'sd128,       32'sd64,       32'sd32
   };

endpackage
`default_nettype wire

// File: rtl/go_to_goal_velocity_controller_top.sv
// Go-to-goal velocity controller: pipelined CORDIC vectoring for distance and
// bearing, then stop / turn / drive decision. Depends on gtgvc_pkg.
//
// Usage:
//  - Pose beats enter on req_* (valid/ready); one velocity beat leaves on rsp_*
//    for each pose, in order.
//  - Target, gain and speed ceiling sit in four csr_ registers, written with
//    csr_wr_en; write them only while the pipeline is empty.
//  - Pipeline: one input stage loaded on the accepting edge, one per CORDIC
//    micro-rotation, four post stages (correction multiply, recombine, gain
//    multiply, saturate).
//  - Throughput: one pose per cycle while the output is not stalled.
//  - Stalls: each stage holds its beat while the one after is full and stalled;
//    bubbles close up, so req_ready drops only once every stage holds a beat
//    and rsp_ready is low.
//  - Reset empties the pipeline and loads the register defaults
//    (target 1.0, 1.0; gain 1.0; max speed 3.0).
`default_nettype none
module go_to_goal_velocity_controller_top #(
   parameter int CORDIC_STAGES = gtgvc_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [gtgvc_pkg::POS_W-1:0]        req_pos_x,
   input  wire logic [gtgvc_pkg::POS_W-1:0]        req_pos_y,
   input  wire logic signed [gtgvc_pkg::HEAD_W-1:0] req_heading,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [gtgvc_pkg::POS_W-1:0]             rsp_linear_speed,
   output logic [gtgvc_pkg::ANG_W-1:0]             rsp_angular_speed,
   input  wire logic                               csr_wr_en,
   input  wire logic [gtgvc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [gtgvc_pkg::POS_W-1:0]        csr_wr_data
);
   import gtgvc_pkg::*;

   localparam int NST   = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
   localparam int ST_PA = NST + 1;
   localparam int ST_PB = NST + 2;
   localparam int ST_PC = NST + 3;
   localparam int ST_PD = NST + 4;
   localparam int DEPTH = NST + 5;

   // configuration registers
   logic [POS_W-1:0] target_x_ff, target_y_ff, gain_ff, max_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff  <= TARGET_X_RST;
         target_y_ff  <= TARGET_Y_RST;
         gain_ff      <= GAIN_RST;
         max_speed_ff <= MAX_SPEED_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TARGET_X:  target_x_ff  <= csr_wr_data;
            CSR_TARGET_Y:  target_y_ff  <= csr_wr_data;
            CSR_GAIN:      gain_ff      <= csr_wr_data;
            CSR_MAX_SPEED: max_speed_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // valid chain: a stage loads when empty or when its beat moves on
   logic [DEPTH-1:0] v_ff, v_in, en;

   assign en[DEPTH-1] = !v_ff[DEPTH-1] || rsp_ready;
   for (genvar k = 0; k < DEPTH - 1; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end
   assign v_in = {v_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (en & v_in) | (~en & v_ff);
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[ST_PD];

   // input stage: offsets and quadrant pre-rotation
   logic signed [POS_W:0]  dx_in, dy_in;
   logic signed [CW-1:0]   gx_in, gy_in, x0_in, y0_in;
   logic signed [ZW-1:0]   z0_in;

   always_comb begin
      dx_in = signed'({1'b0, target_x_ff}) - signed'({1'b0, req_pos_x});
      dy_in = signed'({1'b0, target_y_ff}) - signed'({1'b0, req_pos_y});
      gx_in = CW'(dx_in) <<< GUARD_BITS;
      gy_in = CW'(dy_in) <<< GUARD_BITS;
      x0_in = gx_in;
      y0_in = gy_in;
      z0_in = '0;
      if (gx_in[CW-1]) begin
         if (!gy_in[CW-1]) begin
            x0_in = gy_in;
            y0_in = -gx_in;
            z0_in = HALF_PI_Q28;
         end else begin
            x0_in = -gy_in;
            y0_in = gx_in;
            z0_in = -HALF_PI_Q28;
         end
      end
   end

   logic signed [CW-1:0]     cx_ff [0:NST];
   logic signed [CW-1:0]     cy_ff [0:NST];
   logic signed [ZW-1:0]     cz_ff [0:NST];
   logic signed [HEAD_W-1:0] hd_ff [0:NST];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         cx_ff[0] <= x0_in;
         cy_ff[0] <= y0_in;
         cz_ff[0] <= z0_in;
         hd_ff[0] <= req_heading;
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < NST; i++) begin : g_cordic
      logic signed [CW-1:0] sx, sy, nx_in, ny_in;
      logic signed [ZW-1:0] nz_in;

      always_comb begin
         sx = cx_ff[i] >>> i;
         sy = cy_ff[i] >>> i;
         if (!cy_ff[i][CW-1]) begin
            nx_in = cx_ff[i] + sy;
            ny_in = cy_ff[i] - sx;
            nz_in = cz_ff[i] + ATAN_Q28[i];
         end else begin
            nx_in = cx_ff[i] - sy;
            ny_in = cy_ff[i] + sx;
            nz_in = cz_ff[i] - ATAN_Q28[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en[i+1]) begin
            cx_ff[i+1] <= nx_in;
            cy_ff[i+1] <= ny_in;
            cz_ff[i+1] <= nz_in;
            hd_ff[i+1] <= hd_ff[i];
         end
      end
   end

   // stage A: gain-correction partial products, bearing rounding
   logic signed [CW-1:0]     xfin;
   logic [CW-2:0]            xmag;
   logic signed [ZW-1:0]     zr_in;
   logic [PW-1:0]            phi_in, plo_in, phi_ff, plo_ff;
   logic                     xpos_in, xpos_ff;
   logic signed [BEAR_W-1:0] bear_in, bear_ff;
   logic signed [HEAD_W-1:0] hda_ff;

   always_comb begin
      xfin    = cx_ff[NST];
      xmag    = xfin[CW-2:0];
      xpos_in = !xfin[CW-1] && (xfin != '0);
      phi_in  = PW'(xmag) * PW'(K_HI);
      plo_in  = PW'(xmag) * PW'(K_LO);
      zr_in   = cz_ff[NST] + BEAR_ROUND;
      bear_in = zr_in[ZW-1:BEAR_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (en[ST_PA]) begin
         phi_ff  <= phi_in;
         plo_ff  <= plo_in;
         xpos_ff <= xpos_in;
         bear_ff <= bear_in;
         hda_ff  <= hd_ff[NST];
      end
   end

   // stage B: distance and heading error
   logic [SUM_W-1:0]        sum_in;
   logic [DIST_W-1:0]       dist_in, dist_ff;
   logic signed [ERR_W-1:0] err_in, err_ff;

   always_comb begin
      sum_in  = (SUM_W'(phi_ff) << PART_W) + SUM_W'(plo_ff);
      dist_in = xpos_ff ? sum_in[SUM_W-1:DIST_SHIFT] : '0;
      err_in  = ERR_W'(bear_ff) - ERR_W'(hda_ff);
   end

   always_ff @(posedge clock) begin
      if (en[ST_PB]) begin
         dist_ff <= dist_in;
         err_ff  <= err_in;
      end
   end

   // stage C: gain multiply, turn and stop decisions
   logic [LIN_PW-1:0] prod_in, prod_ff;
   logic [ERR_W-1:0]  aerr_in;
   logic [ANG_W-1:0]  aerr_ff;
   logic              turn_in, turn_ff, stop_in, stop_ff;

   always_comb begin
      prod_in = LIN_PW'(gain_ff) * LIN_PW'(dist_ff);
      aerr_in = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
      turn_in = aerr_in > TURN_ERR;
      stop_in = dist_ff <= STOP_DIST;
   end

   always_ff @(posedge clock) begin
      if (en[ST_PC]) begin
         prod_ff <= prod_in;
         aerr_ff <= aerr_in[ANG_W-1:0];
         turn_ff <= turn_in;
         stop_ff <= stop_in;
      end
   end

   // stage D: saturate and select, output register
   logic [LIN_PW-FRAC_W-1:0] lraw;
   logic [POS_W-1:0]         lin_in, lin_ff;
   logic [ANG_W-1:0]         ang_in, ang_ff;

   always_comb begin
      lraw   = prod_ff[LIN_PW-1:FRAC_W];
      lin_in = (lraw > (LIN_PW-FRAC_W)'(max_speed_ff)) ? max_speed_ff : lraw[POS_W-1:0];
      ang_in = '0;
      if (stop_ff) begin
         lin_in = '0;
      end else if (turn_ff) begin
         lin_in = '0;
         ang_in = aerr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_PD]) begin
         lin_ff <= lin_in;
         ang_ff <= ang_in;
      end
   end

   assign rsp_linear_speed  = lin_ff;
   assign rsp_angular_speed = ang_ff;

   // never both a drive and a turn command
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_linear_speed == '0 || rsp_angular_speed == '0))
      else $error("drive and turn both non-zero");

   // a turn beat always exceeds the turn threshold
   a_turn_thr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_angular_speed != '0) |-> (ERR_W'(rsp_angular_speed) > TURN_ERR))
      else $error("turn rate below threshold");

   // speed ceiling honoured
   a_lin_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_linear_speed <= max_speed_ff))
      else $error("linear speed above ceiling");

   // back-pressure reaches the input only with every stage occupied
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&v_ff && !rsp_ready))
      else $error("input stalled with a bubble in the pipeline");

endmodule
`default_nettype wire
